// File: sv/seq_pkg.sv
// Shared types and constants for the sorted event queue.
package seq_pkg;

  localparam int DEPTH_DEF = 16;

  localparam int TIME_W   = 32;
  localparam int TARGET_W = 16;
  localparam int KIND_W   = 8;
  localparam int STATUS_W = 2;

  localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_LISTED   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_LIST   = 1'b1;

  typedef struct packed {
    logic [TIME_W-1:0]   ev_time;
    logic [TARGET_W-1:0] target;
    logic [KIND_W-1:0]   kind;
  } seq_entry_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_ROTATE
  } seq_op_t;

  typedef struct packed {
    seq_op_t    op;
    seq_entry_t new_entry;
    seq_entry_t head_entry;
  } seq_ctrl_t;

endpackage

// File: sv/seq_cell.sv
// One storage cell of the sorted chain: compare, keep, shift or rotate.
module seq_cell
  import seq_pkg::*;
(
  input  logic       clk,
  input  seq_ctrl_t  ctrl,
  input  seq_entry_t left_entry,
  input  seq_entry_t right_entry,
  input  logic       left_keep,
  input  logic       occupied,
  input  logic       is_tail,
  output seq_entry_t entry,
  output logic       keep
);

  seq_entry_t entry_r;
  seq_entry_t entry_nxt;

  // An occupied cell with an earlier time stays put on insert.
  assign keep  = occupied && (entry_r.ev_time < ctrl.new_entry.ev_time);
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    case (ctrl.op)
      OP_INSERT: begin
        if (!keep) begin
          entry_nxt = left_keep ? ctrl.new_entry : left_entry;
        end
      end
      OP_ROTATE: begin
        entry_nxt = is_tail ? ctrl.head_entry : right_entry;
      end
      default: entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

// File: sv/sorted_event_queue_core.sv
// Sorted event queue: a chain of cells kept in ascending time order.
// Insert: status strobed on the cycle after accept; busy stays low.
// List: count results, one per cycle, first after the state and output registers; busy
//   is high while the chain rotates once through its occupied cells.
// Empty list and full insert give one result on the cycle after accept.
// Synchronous active-low reset clears the entry count and control; cell contents stay.
module sorted_event_queue_core
  import seq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic                in_command,
  input  logic [TIME_W-1:0]   in_event_time,
  input  logic [TARGET_W-1:0] in_target_id,
  input  logic [KIND_W-1:0]   in_event_kind,
  output logic                out_valid,
  output logic [STATUS_W-1:0] out_status,
  output logic [TIME_W-1:0]   out_time,
  output logic [TARGET_W-1:0] out_target,
  output logic [KIND_W-1:0]   out_kind,
  output logic                out_is_last
);

  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic {
    S_IDLE,
    S_LIST
  } state_t;

  state_t              state_r;
  logic [CW-1:0]       count_r;
  logic [CW-1:0]       idx_r;
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [TIME_W-1:0]   out_time_r;
  logic [TARGET_W-1:0] out_target_r;
  logic [KIND_W-1:0]   out_kind_r;
  logic                out_is_last_r;

  logic       accept;
  logic       full;
  logic       list_last;
  seq_ctrl_t  ctrl;
  seq_entry_t cell_entry [DEPTH];
  logic       cell_keep  [DEPTH];

  assign busy      = (state_r == S_LIST);
  assign accept    = start && !busy;
  assign full      = (count_r == CW'(DEPTH));
  assign list_last = ((idx_r + CW'(1)) == count_r);

  always_comb begin
    ctrl.new_entry  = '{ev_time: in_event_time, target: in_target_id, kind: in_event_kind};
    ctrl.head_entry = cell_entry[0];
    if (state_r == S_LIST) begin
      ctrl.op = OP_ROTATE;
    end else if (accept && (in_command == CMD_INSERT) && !full) begin
      ctrl.op = OP_INSERT;
    end else begin
      ctrl.op = OP_HOLD;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    seq_entry_t left_e;
    seq_entry_t right_e;
    logic       left_k;

    if (i == 0) begin : g_first
      assign left_e = ctrl.new_entry;
      assign left_k = 1'b1;
    end else begin : g_mid
      assign left_e = cell_entry[i-1];
      assign left_k = cell_keep[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_e = cell_entry[0];
    end else begin : g_inner
      assign right_e = cell_entry[i+1];
    end

    seq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .left_entry  (left_e),
      .right_entry (right_e),
      .left_keep   (left_k),
      .occupied    (count_r > CW'(i)),
      .is_tail     (count_r == CW'(i + 1)),
      .entry       (cell_entry[i]),
      .keep        (cell_keep[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            out_valid_r   <= 1'b1;
            out_is_last_r <= 1'b1;
            out_time_r    <= '0;
            out_target_r  <= '0;
            out_kind_r    <= '0;
            if (in_command == CMD_INSERT) begin
              if (full) begin
                out_status_r <= ST_FULL;
              end else begin
                out_status_r <= ST_INSERTED;
                count_r      <= count_r + CW'(1);
              end
            end else if (count_r == '0) begin
              out_status_r <= ST_EMPTY;
            end else begin
              // hold the strobe; the rotation emits the entries
              out_valid_r <= 1'b0;
              idx_r       <= '0;
              state_r     <= S_LIST;
            end
          end
        end
        S_LIST: begin
          out_valid_r   <= 1'b1;
          out_status_r  <= ST_LISTED;
          out_time_r    <= cell_entry[0].ev_time;
          out_target_r  <= cell_entry[0].target;
          out_kind_r    <= cell_entry[0].kind;
          out_is_last_r <= list_last;
          idx_r         <= idx_r + CW'(1);
          if (list_last) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_time    = out_time_r;
  assign out_target  = out_target_r;
  assign out_kind    = out_kind_r;
  assign out_is_last = out_is_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count exceeds depth");

  a_list_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> (count_r != '0) && (idx_r < count_r))
    else $error("listing with index outside the stored entries");

  a_list_emits: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> out_valid && (out_status == ST_LISTED))
    else $error("listing cycle without a listed entry");

  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_command == CMD_INSERT) && full) |=>
      out_valid && (out_status == ST_FULL) && $stable(count_r))
    else $error("insert into full store not dropped");

endmodule
